/* hdl/trial_division_factorizer_core_macros.svh */
// assertion macros for the trial division factorizer
`ifndef TRIAL_DIVISION_FACTORIZER_CORE_MACROS_SVH
`define TRIAL_DIVISION_FACTORIZER_CORE_MACROS_SVH

// same-cycle implication, checked outside reset
`define TDF_ASSERT_SAME(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("tdf same-cycle check failed");

// next-cycle implication, checked outside reset
`define TDF_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("tdf next-cycle check failed");

`endif

/* hdl/tdf_pkg.sv */
// shared types and constants for the trial division factorizer
`timescale 1ns / 1ps
package tdf_pkg;

  localparam int EXP_BITS = 6;

  typedef struct packed {
    logic load;
    logic div_start;
    logic take_quotient;
    logic next_divisor;
    logic push_factor;
    logic push_rem;
    logic flush;
  } tdf_cmd_t;

  typedef struct packed {
    logic value_zero;
    logic div_done;
    logic d_gt_q;
    logic r_zero;
    logic rem_gt1;
  } tdf_status_t;

endpackage

/* hdl/tdf_divider.sv */
// iterative restoring divider, one quotient bit per cycle
`timescale 1ns / 1ps
module tdf_divider #(
  parameter int VALUE_BITS = 40,
  parameter int DIV_BITS   = 21
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  start,
  input  logic [VALUE_BITS-1:0] dividend,
  input  logic [DIV_BITS-1:0]   divisor,
  output logic                  done,
  output logic [VALUE_BITS-1:0] quotient,
  output logic [DIV_BITS-1:0]   remainder
);
  localparam int CNT_BITS = (VALUE_BITS > 1) ? $clog2(VALUE_BITS) : 1;

  logic [VALUE_BITS-1:0] quo_r;
  logic [DIV_BITS-1:0]   part_r;
  logic [CNT_BITS-1:0]   cnt_r;
  logic                  run_r;
  logic                  done_r;

  logic [DIV_BITS:0] acc;
  logic [DIV_BITS:0] diff;
  logic              ge;

  assign acc  = {part_r, quo_r[VALUE_BITS-1]};
  assign ge   = acc >= {1'b0, divisor};
  assign diff = acc - {1'b0, divisor};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      done_r <= 1'b0;
    end else if (start) begin
      run_r  <= 1'b1;
      done_r <= 1'b0;
    end else if (run_r && (cnt_r == CNT_BITS'(VALUE_BITS - 1))) begin
      run_r  <= 1'b0;
      done_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quo_r  <= dividend;
      part_r <= '0;
      cnt_r  <= '0;
    end else if (run_r) begin
      quo_r  <= {quo_r[VALUE_BITS-2:0], ge};
      part_r <= ge ? diff[DIV_BITS-1:0] : acc[DIV_BITS-1:0];
      cnt_r  <= cnt_r + CNT_BITS'(1);
    end
  end

  assign done      = done_r;
  assign quotient  = quo_r;
  assign remainder = part_r;
endmodule

/* hdl/tdf_datapath.sv */
// remainder, divisor, exponent, pending result and output registers
`timescale 1ns / 1ps
module tdf_datapath #(
  parameter int VALUE_BITS = 40,
  parameter int DIV_BITS   = 21
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic [VALUE_BITS-1:0]         in_value,
  input  tdf_pkg::tdf_cmd_t             cmd,
  output tdf_pkg::tdf_status_t          status,
  output logic                          out_valid,
  output logic [VALUE_BITS-1:0]         out_prime_factor,
  output logic [tdf_pkg::EXP_BITS-1:0]  out_exponent,
  output logic                          out_last,
  output logic                          out_invalid
);
  import tdf_pkg::*;

  logic [VALUE_BITS-1:0] rem_r, rem_nxt;
  logic [DIV_BITS-1:0]   d_r, d_nxt;
  logic [EXP_BITS-1:0]   exp_r, exp_nxt;

  logic                  pend_valid_r, pend_valid_nxt;
  logic [VALUE_BITS-1:0] pend_prime_r, pend_prime_nxt;
  logic [EXP_BITS-1:0]   pend_exp_r, pend_exp_nxt;
  logic                  pend_invalid_r, pend_invalid_nxt;

  logic                  out_valid_r, out_valid_nxt;
  logic [VALUE_BITS-1:0] out_prime_r, out_prime_nxt;
  logic [EXP_BITS-1:0]   out_exp_r, out_exp_nxt;
  logic                  out_last_r, out_last_nxt;
  logic                  out_invalid_r, out_invalid_nxt;

  logic                  div_done;
  logic [VALUE_BITS-1:0] quo;
  logic [DIV_BITS-1:0]   part;

  tdf_divider #(
    .VALUE_BITS(VALUE_BITS),
    .DIV_BITS  (DIV_BITS)
  ) u_divider (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (cmd.div_start),
    .dividend (rem_r),
    .divisor  (d_r),
    .done     (div_done),
    .quotient (quo),
    .remainder(part)
  );

  always_comb begin
    rem_nxt          = rem_r;
    d_nxt            = d_r;
    exp_nxt          = exp_r;
    pend_valid_nxt   = pend_valid_r;
    pend_prime_nxt   = pend_prime_r;
    pend_exp_nxt     = pend_exp_r;
    pend_invalid_nxt = pend_invalid_r;
    out_valid_nxt    = 1'b0;
    out_prime_nxt    = out_prime_r;
    out_exp_nxt      = out_exp_r;
    out_last_nxt     = out_last_r;
    out_invalid_nxt  = out_invalid_r;

    if (cmd.load) begin
      rem_nxt          = in_value;
      d_nxt            = DIV_BITS'(2);
      exp_nxt          = '0;
      pend_valid_nxt   = (in_value == '0);
      pend_prime_nxt   = '0;
      pend_exp_nxt     = '0;
      pend_invalid_nxt = 1'b1;
    end

    if (cmd.take_quotient) begin
      rem_nxt = quo;
      exp_nxt = exp_r + EXP_BITS'(1);
    end

    if (cmd.next_divisor) begin
      d_nxt   = (d_r == DIV_BITS'(2)) ? DIV_BITS'(3) : d_r + DIV_BITS'(2);
      exp_nxt = '0;
    end

    if (cmd.push_factor || cmd.push_rem) begin
      if (pend_valid_r) begin
        out_valid_nxt   = 1'b1;
        out_prime_nxt   = pend_prime_r;
        out_exp_nxt     = pend_exp_r;
        out_last_nxt    = 1'b0;
        out_invalid_nxt = pend_invalid_r;
      end
      pend_valid_nxt   = 1'b1;
      pend_prime_nxt   = cmd.push_factor ? VALUE_BITS'(d_r) : rem_r;
      pend_exp_nxt     = cmd.push_factor ? exp_r : EXP_BITS'(1);
      pend_invalid_nxt = 1'b0;
    end

    if (cmd.flush) begin
      if (pend_valid_r) begin
        out_valid_nxt   = 1'b1;
        out_prime_nxt   = pend_prime_r;
        out_exp_nxt     = pend_exp_r;
        out_last_nxt    = 1'b1;
        out_invalid_nxt = pend_invalid_r;
      end
      pend_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_valid_r <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      pend_valid_r <= pend_valid_nxt;
      out_valid_r  <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rem_r          <= rem_nxt;
    d_r            <= d_nxt;
    exp_r          <= exp_nxt;
    pend_prime_r   <= pend_prime_nxt;
    pend_exp_r     <= pend_exp_nxt;
    pend_invalid_r <= pend_invalid_nxt;
    out_prime_r    <= out_prime_nxt;
    out_exp_r      <= out_exp_nxt;
    out_last_r     <= out_last_nxt;
    out_invalid_r  <= out_invalid_nxt;
  end

  assign status.value_zero = (in_value == '0);
  assign status.div_done   = div_done;
  assign status.d_gt_q     = VALUE_BITS'(d_r) > quo;
  assign status.r_zero     = (part == '0);
  assign status.rem_gt1    = rem_r > VALUE_BITS'(1);

  assign out_valid        = out_valid_r;
  assign out_prime_factor = out_prime_r;
  assign out_exponent     = out_exp_r;
  assign out_last         = out_last_r;
  assign out_invalid      = out_invalid_r;
endmodule

/* hdl/tdf_ctrl.sv */
// controller state machine for the trial division search
`timescale 1ns / 1ps
module tdf_ctrl (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 start,
  input  tdf_pkg::tdf_status_t status,
  output tdf_pkg::tdf_cmd_t    cmd,
  output logic                 busy
);
  import tdf_pkg::*;

  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_INIT  = 3'd1;
  localparam logic [2:0] ST_RUN   = 3'd2;
  localparam logic [2:0] ST_EVAL  = 3'd3;
  localparam logic [2:0] ST_FINAL = 3'd4;
  localparam logic [2:0] ST_FLUSH = 3'd5;

  logic [2:0] state_r, state_nxt;
  logic       inner_r, inner_nxt;

  always_comb begin
    state_nxt = state_r;
    inner_nxt = inner_r;
    cmd       = '0;
    unique case (state_r)
      ST_IDLE: begin
        if (start) begin
          cmd.load  = 1'b1;
          inner_nxt = 1'b0;
          state_nxt = status.value_zero ? ST_FLUSH : ST_INIT;
        end
      end
      ST_INIT: begin
        cmd.div_start = 1'b1;
        state_nxt     = ST_RUN;
      end
      ST_RUN: begin
        if (status.div_done) begin
          state_nxt = ST_EVAL;
        end
      end
      ST_EVAL: begin
        state_nxt = ST_INIT;
        if (inner_r) begin
          if (status.r_zero) begin
            cmd.take_quotient = 1'b1;
          end else begin
            cmd.push_factor  = 1'b1;
            cmd.next_divisor = 1'b1;
            inner_nxt        = 1'b0;
          end
        end else if (status.d_gt_q) begin
          state_nxt = ST_FINAL;
        end else if (status.r_zero) begin
          cmd.take_quotient = 1'b1;
          inner_nxt         = 1'b1;
        end else begin
          cmd.next_divisor = 1'b1;
        end
      end
      ST_FINAL: begin
        cmd.push_rem = status.rem_gt1;
        state_nxt    = ST_FLUSH;
      end
      ST_FLUSH: begin
        cmd.flush = 1'b1;
        state_nxt = ST_IDLE;
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      inner_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      inner_r <= inner_nxt;
    end
  end

  assign busy = (state_r != ST_IDLE);
endmodule

/* hdl/trial_division_factorizer_core.sv */
// top level of the trial division factorizer
//
//   channel | ports                                         | transfer
//   --------+-----------------------------------------------+---------------------
//   input   | start, busy, in_value                         | start high, busy low
//   result  | out_valid, out_prime_factor, out_exponent,    | out_valid high,
//           | out_last, out_invalid                         | one cycle, no stall
//
// each trial division runs through the bit-serial divider
// an item takes a division per divisor tried and per quotient taken,
// up to about 2^(VALUE_BITS/2 - 1) divisions when the input is a large prime
// busy stays high from an accepted item until its last result, if any, appears
// synchronous active-low reset returns the controller to idle, no results pending
`timescale 1ns / 1ps
`include "trial_division_factorizer_core_macros.svh"
module trial_division_factorizer_core #(
  parameter int VALUE_BITS = 40
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         start,
  output logic                         busy,
  input  logic [VALUE_BITS-1:0]        in_value,
  output logic                         out_valid,
  output logic [VALUE_BITS-1:0]        out_prime_factor,
  output logic [tdf_pkg::EXP_BITS-1:0] out_exponent,
  output logic                         out_last,
  output logic                         out_invalid
);
  import tdf_pkg::*;

  localparam int DIV_BITS = (VALUE_BITS + 1) / 2 + 1;

  tdf_cmd_t    cmd;
  tdf_status_t status;

  tdf_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .status(status),
    .cmd   (cmd),
    .busy  (busy)
  );

  tdf_datapath #(
    .VALUE_BITS(VALUE_BITS),
    .DIV_BITS  (DIV_BITS)
  ) u_datapath (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_value        (in_value),
    .cmd             (cmd),
    .status          (status),
    .out_valid       (out_valid),
    .out_prime_factor(out_prime_factor),
    .out_exponent    (out_exponent),
    .out_last        (out_last),
    .out_invalid     (out_invalid)
  );

  `TDF_ASSERT_SAME(a_invalid_is_last, clk, rst_n, out_valid && out_invalid, out_last && (out_prime_factor == '0))
  `TDF_ASSERT_SAME(a_last_when_idle, clk, rst_n, out_valid && out_last, !busy)
  `TDF_ASSERT_SAME(a_more_while_busy, clk, rst_n, out_valid && !out_last, busy)
  `TDF_ASSERT_SAME(a_prime_above_one, clk, rst_n, out_valid && !out_invalid, out_prime_factor > VALUE_BITS'(1))
  `TDF_ASSERT_NEXT(a_accept_goes_busy, clk, rst_n, start && !busy, busy)
endmodule
